// ===== sv/sc_pkg.sv =====
// Shared types and constants for the stack calculator.
package sc_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int WORD_W      = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DIV_CNT_W   = $clog2(WORD_W);

	// Command codes on the kind input
	typedef enum logic [3:0] {
		CMD_PUSH  = 4'd0,
		CMD_POP   = 4'd1,
		CMD_SIZE  = 4'd2,
		CMD_EMPTY = 4'd3,
		CMD_TOP   = 4'd4,
		CMD_ADD   = 4'd5,
		CMD_SUB   = 4'd6,
		CMD_MUL   = 4'd7,
		CMD_DIV   = 4'd8
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_ERR = 2'd1,
		STAT_OVF = 2'd2
	} stat_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== sv/sc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/sc_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sc_div
	import sc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    rem_q;
	logic [WORD_W-1:0]    dvd_q;
	logic [WORD_W-1:0]    dsr_q;
	logic [WORD_W:0]      trial;
	logic [WORD_W-1:0]    mag_a;
	logic [WORD_W-1:0]    mag_b;

	// Operand magnitudes; the minimum value maps onto itself, which is its magnitude
	assign mag_a = req.dividend[WORD_W-1] ? (WORD_W'(0) - req.dividend) : req.dividend;
	assign mag_b = req.divisor[WORD_W-1]  ? (WORD_W'(0) - req.divisor)  : req.divisor;

	// Trial subtract of the shifted remainder
	assign trial = {rem_q, dvd_q[WORD_W-1]} - {1'b0, dsr_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: restoring division, quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= mag_a;
			dsr_q <= mag_b;
			neg_q <= req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
		end else if (busy_q) begin
			if (!trial[WORD_W]) begin
				rem_q <= trial[WORD_W-1:0];
				dvd_q <= {dvd_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WORD_W-2:0], dvd_q[WORD_W-1]};
				dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (WORD_W'(0) - dvd_q) : dvd_q;

endmodule

// ===== sv/stack_calculator.sv =====
// Stack calculator: stack memory with cached top entry, ALU and iterative divider.
// A push below full stays idle and gives no transfer out; the next item may follow at once.
// Size, empty, top, overflow, and pop or arithmetic on under two entries go straight to finish;
// other pops, add, sub, mul and divide by zero go via execute; div waits on the 32-step divider.
// One item is in work at a time; the output register lets the next item in while a
// result waits. Reset clears the entry count and control; memory is not cleared.
module stack_calculator
	import sc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [3:0]               kind,
	input  logic signed [WORD_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] result_value,
	output logic [1:0]               status
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t            state_q;
	cmd_t              op_q;
	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] top_q;
	logic [WORD_W-1:0] res_q;
	stat_t             stat_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_value_q;
	stat_t             out_stat_q;

	logic              accept;
	logic              out_free;
	logic [CNT_W-1:0]  cnt_m2;
	logic              full;
	logic              empty;
	logic              lt_two;
	logic [WORD_W-1:0] left;
	logic [WORD_W-1:0] right;
	logic [WORD_W-1:0] alu_res;
	logic [WORD_W-1:0] commit_val;
	logic              commit;
	logic              is_alu;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] rdata;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cnt_m2   = count_q - CNT_W'(2);
	assign full     = (count_q == CNT_W'(STACK_DEPTH));
	assign empty    = (count_q == '0);
	assign lt_two   = (count_q < CNT_W'(2));

	// Second entry comes from memory, top from the cached register
	assign left  = rdata;
	assign right = top_q;
	assign is_alu = (op_q == CMD_ADD) || (op_q == CMD_SUB) || (op_q == CMD_MUL);

	// ALU for add, sub and mul
	always_comb begin
		unique case (op_q)
			CMD_ADD: alu_res = left + right;
			CMD_SUB: alu_res = left - right;
			default: alu_res = left * right;
		endcase
	end

	assign commit     = ((state_q == S_EXEC) && is_alu) || ((state_q == S_DIV) && div_rsp.done);
	assign commit_val = (state_q == S_DIV) ? div_rsp.quotient : alu_res;

	// Divider start when the right operand is nonzero
	assign div_req.start    = (state_q == S_EXEC) && (op_q == CMD_DIV) && (right != '0);
	assign div_req.dividend = left;
	assign div_req.divisor  = right;

	// Memory write: push at the count, arithmetic result over the second entry
	always_comb begin
		we    = 1'b0;
		waddr = count_q[ADDR_W-1:0];
		wdata = push_value;
		if (accept && (cmd_t'(kind) == CMD_PUSH) && !full) begin
			we = 1'b1;
		end else if (commit) begin
			we    = 1'b1;
			waddr = cnt_m2[ADDR_W-1:0];
			wdata = commit_val;
		end
	end

	sc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (cnt_m2[ADDR_W-1:0]),
		.rdata (rdata)
	);

	sc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Command sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			op_q    <= CMD_PUSH;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= cmd_t'(kind);
						unique case (kind)
							CMD_PUSH: begin
								if (full) begin
									state_q <= S_FIN;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_POP: begin
								if (!empty) begin
									count_q <= count_q - CNT_W'(1);
								end
								state_q <= lt_two ? S_FIN : S_EXEC;
							end
							CMD_SIZE, CMD_EMPTY, CMD_TOP: state_q <= S_FIN;
							CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
								state_q <= lt_two ? S_FIN : S_EXEC;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_EXEC: begin
					if (commit) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_FIN;
					end else if (div_req.start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DIV: begin
					if (commit) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Top cache and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (kind)
				CMD_PUSH: begin
					if (!full) begin
						top_q <= push_value;
					end
					res_q  <= '0;
					stat_q <= STAT_OVF;
				end
				CMD_POP, CMD_TOP: begin
					res_q  <= empty ? '1 : top_q;
					stat_q <= STAT_OK;
				end
				CMD_SIZE: begin
					res_q  <= WORD_W'(count_q);
					stat_q <= STAT_OK;
				end
				CMD_EMPTY: begin
					res_q  <= WORD_W'(empty);
					stat_q <= STAT_OK;
				end
				default: begin
					res_q  <= '0;
					stat_q <= STAT_ERR;
				end
			endcase
		end else if (commit) begin
			top_q  <= commit_val;
			res_q  <= commit_val;
			stat_q <= STAT_OK;
		end else if ((state_q == S_EXEC) && (op_q == CMD_POP)) begin
			// Refill the cached top after a pop
			top_q <= rdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			out_value_q <= res_q;
			out_stat_q  <= stat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_stat_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("entry count above stack depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1))))
		else $error("entry count moved by more than one");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result loaded outside finish state");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (top_q != '0) && !lt_two)
		else $error("divider started with zero divisor or short stack");

	a_no_write_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && commit) |-> 1'b0)
		else $error("push and arithmetic write in the same cycle");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the stack calculator: directed script, then random traffic.
`timescale 1ns / 1ps

module tb;
	import sc_pkg::*;

	localparam int ITEM_TARGET   = 1850;
	localparam int WATCHDOG_MAX  = 3000;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER    = 500;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_MAX    = 10;

	// Kind codes the block has no command for
	localparam logic [3:0] CMD_RESERVED_LO = 4'd9;
	localparam logic [3:0] CMD_RESERVED_HI = 4'd15;

	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

	typedef struct {
		logic [WORD_W-1:0] value;
		logic [1:0]        code;
	} calc_result_t;

	// One line of the directed script; typed rows carry their own expected result
	typedef struct packed {
		logic [3:0]        op;
		logic [WORD_W-1:0] operand;
		logic              typed;
		logic [WORD_W-1:0] want_value;
		logic [1:0]        want_status;
	} script_row_t;

	typedef enum logic [1:0] {
		PH_MIX,
		PH_FILL,
		PH_DRAIN
	} stim_phase_t;

	localparam int SCRIPT_LEN = 25;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{CMD_SIZE,        32'h0000_0000, 1'b1, 32'h0000_0000, STAT_OK},
		'{CMD_EMPTY,       32'h0000_0000, 1'b1, 32'h0000_0001, STAT_OK},
		'{CMD_POP,         32'h0000_0000, 1'b1, 32'hFFFF_FFFF, STAT_OK},
		'{CMD_TOP,         32'h0000_0000, 1'b1, 32'hFFFF_FFFF, STAT_OK},
		'{CMD_ADD,         32'h0000_0000, 1'b1, 32'h0000_0000, STAT_ERR},
		'{CMD_RESERVED_HI, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_PUSH,        32'h8000_0000, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_SUB,         32'h0000_0000, 1'b1, 32'h0000_0000, STAT_ERR},
		'{CMD_PUSH,        32'hFFFF_FFFF, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_DIV,         32'h0000_0000, 1'b1, 32'h8000_0000, STAT_OK},
		'{CMD_PUSH,        32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_DIV,         32'h0000_0000, 1'b1, 32'h0000_0000, STAT_ERR},
		'{CMD_MUL,         32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_PUSH,        32'h7FFF_FFFF, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_PUSH,        32'h7FFF_FFFF, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_MUL,         32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_PUSH,        32'hFFFF_FFF9, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_ADD,         32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_PUSH,        32'h0000_0004, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_DIV,         32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_TOP,         32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_SIZE,        32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_POP,         32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_RESERVED_LO, 32'hDEAD_BEEF, 1'b0, 32'h0000_0000, STAT_OK},
		'{CMD_EMPTY,       32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK}
	};

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     in_valid     = 1'b0;
	logic                     in_stall;
	logic [3:0]               kind         = 4'd0;
	logic signed [WORD_W-1:0] push_value   = '0;
	logic                     out_valid;
	logic                     out_stall    = 1'b0;
	logic signed [WORD_W-1:0] result_value;
	logic [1:0]               status;

	// Predicted stack contents
	logic [WORD_W-1:0] calc_stack [STACK_DEPTH];
	int                calc_depth = 0;

	calc_result_t pending_results[$];
	calc_result_t head;

	int failures       = 0;
	int results_checked = 0;
	int commands_sent  = 0;
	int ignored_sent   = 0;
	int overflow_hits  = 0;
	int error_hits     = 0;
	int deepest        = 0;
	int burst_left     = 0;
	int idle_cycles    = 0;
	bit hold_done      = 1'b0;

	stack_calculator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.status       (status)
	);

	always #1 clk = ~clk;

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= REPORT_MAX)
			$display("MISMATCH: %s", msg);
	endtask

	// Apply one command to the predicted stack and work out its result, if any
	task automatic apply_command(input logic [3:0] op, input logic [WORD_W-1:0] operand,
			output bit has_res, output logic [WORD_W-1:0] res_value,
			output logic [1:0] res_code);
		logic signed [WORD_W-1:0] lhs;
		logic signed [WORD_W-1:0] rhs;
		has_res   = 1'b1;
		res_value = '0;
		res_code  = STAT_OK;
		case (op)
			CMD_PUSH: begin
				if (calc_depth >= STACK_DEPTH) begin
					res_code = STAT_OVF;
				end else begin
					calc_stack[calc_depth] = operand;
					calc_depth++;
					has_res = 1'b0;
				end
			end
			CMD_POP: begin
				if (calc_depth == 0) begin
					res_value = '1;
				end else begin
					calc_depth--;
					res_value = calc_stack[calc_depth];
				end
			end
			CMD_SIZE:  res_value = calc_depth;
			CMD_EMPTY: res_value = (calc_depth == 0) ? 1 : 0;
			CMD_TOP:   res_value = (calc_depth == 0) ? '1 : calc_stack[calc_depth - 1];
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
				if (calc_depth < 2) begin
					res_code = STAT_ERR;
				end else begin
					lhs = calc_stack[calc_depth - 2];
					rhs = calc_stack[calc_depth - 1];
					if (op == CMD_DIV && rhs == 0) begin
						res_code = STAT_ERR;
					end else begin
						case (op)
							CMD_ADD: res_value = lhs + rhs;
							CMD_SUB: res_value = lhs - rhs;
							CMD_MUL: res_value = lhs * rhs;
							default: begin
								// most negative word over -1 wraps back to itself
								if (lhs == WORD_MIN && rhs == -1)
									res_value = lhs;
								else
									res_value = lhs / rhs;
							end
						endcase
						calc_depth--;
						calc_stack[calc_depth - 1] = res_value;
					end
				end
			end
			default: has_res = 1'b0;
		endcase
	endtask

	// Offer one item with bursty idling, wait for its transfer, queue what it should produce
	task automatic drive_item(input logic [3:0] op, input logic [WORD_W-1:0] operand,
			input bit typed, input logic [WORD_W-1:0] want_value,
			input logic [1:0] want_status);
		int gap;
		bit has_res;
		logic [WORD_W-1:0] res_value;
		logic [1:0] res_code;
		calc_result_t entry;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				4, 5, 6, 7: gap = $urandom_range(1, 4);
				8:          gap = $urandom_range(5, 30);
				default:    gap = $urandom_range(31, 120);
			endcase
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 40);
		end
		burst_left--;
		in_valid   <= 1'b1;
		kind       <= op;
		push_value <= operand;
		do @(posedge clk); while (in_stall);
		apply_command(op, operand, has_res, res_value, res_code);
		if (typed) begin
			has_res   = 1'b1;
			res_value = want_value;
			res_code  = want_status;
		end
		if (has_res) begin
			entry.value = res_value;
			entry.code  = res_code;
			pending_results.push_back(entry);
			if (res_code == STAT_OVF)
				overflow_hits++;
			if (res_code == STAT_ERR)
				error_hits++;
		end
		if (op <= CMD_DIV)
			commands_sent++;
		else
			ignored_sent++;
		if (calc_depth > deepest)
			deepest = calc_depth;
	endtask

	// Operand values weighted toward the corners
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 11))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			4:       return 32'h0000_0001;
			5, 6:    return $urandom_range(0, 40) - 32'd20;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [3:0] pick_arith();
		case ($urandom_range(0, 3))
			0:       return CMD_ADD;
			1:       return CMD_SUB;
			2:       return CMD_MUL;
			default: return CMD_DIV;
		endcase
	endfunction

	// Stimulus: directed script, then random phases
	initial begin
		stim_phase_t phase;
		int phase_left;
		int tail_left;
		int r;
		bit filled_once;
		logic [3:0] op;
		phase       = PH_MIX;
		phase_left  = 0;
		tail_left   = 0;
		filled_once = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++)
			drive_item(SCRIPT[i].op, SCRIPT[i].operand, SCRIPT[i].typed,
				SCRIPT[i].want_value, SCRIPT[i].want_status);

		while (commands_sent < ITEM_TARGET) begin
			// pick a new phase when the current one has run out
			if (phase_left == 0) begin
				r = $urandom_range(0, 99);
				if (!filled_once && commands_sent > 400)
					phase = PH_FILL;
				else if (r < 80)
					phase = PH_MIX;
				else if (r < 86)
					phase = PH_FILL;
				else
					phase = PH_DRAIN;
				phase_left = (phase == PH_MIX) ? $urandom_range(20, 80) : 1;
				tail_left  = $urandom_range(1, 4);
				if (phase == PH_FILL)
					filled_once = 1'b1;
			end

			r = $urandom_range(0, 99);
			case (phase)
				PH_FILL: begin
					if (calc_depth < STACK_DEPTH) begin
						op = (r < 95) ? CMD_PUSH : ((r < 97) ? CMD_SIZE : CMD_TOP);
					end else begin
						// full: a few pushes that must be dropped
						op = CMD_PUSH;
						tail_left--;
						if (tail_left == 0)
							phase_left = 0;
					end
				end
				PH_DRAIN: begin
					if (calc_depth > 0) begin
						op = (r < 40) ? CMD_POP : ((r < 90) ? pick_arith() : CMD_TOP);
					end else begin
						// empty: commands that must report empty or fail
						case (r % 4)
							0:       op = CMD_POP;
							1:       op = CMD_TOP;
							2:       op = CMD_EMPTY;
							default: op = pick_arith();
						endcase
						tail_left--;
						if (tail_left == 0)
							phase_left = 0;
					end
				end
				default: begin
					if (calc_depth < 2 && r < 60)
						op = CMD_PUSH;
					else if (r < 35)
						op = CMD_PUSH;
					else if (r < 43)
						op = CMD_POP;
					else if (r < 48)
						op = CMD_SIZE;
					else if (r < 52)
						op = CMD_EMPTY;
					else if (r < 58)
						op = CMD_TOP;
					else if (r < 66)
						op = CMD_ADD;
					else if (r < 74)
						op = CMD_SUB;
					else if (r < 82)
						op = CMD_MUL;
					else if (r < 96)
						op = CMD_DIV;
					else
						op = 4'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
					phase_left--;
				end
			endcase
			drive_item(op, (op == CMD_PUSH) ? pick_word() : $urandom(), 1'b0, '0, STAT_OK);
		end
		in_valid <= 1'b0;

		// drain outstanding results, then give the block time to go quiet
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d commands plus %0d unknown codes, %0d results checked",
			commands_sent, ignored_sent, results_checked);
		$display("deepest stack %0d, %0d overflow pushes, %0d operand/divide errors",
			deepest, overflow_hits, error_hits);
		if (failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Receiver stall pattern, with one long hold-off to back the block up
	initial begin
		int mode;
		int len;
		int pct;
		int period;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && commands_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode   = $urandom_range(0, 2);
			len    = $urandom_range(20, 200);
			pct    = $urandom_range(10, 70);
			period = $urandom_range(2, 7);
			for (int c = 0; c < len; c++) begin
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 99) < pct);
					default: out_stall <= ((c % period) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Compare each output transfer with the oldest pending result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: value %h status %0d",
					result_value, status));
			end else begin
				head = pending_results.pop_front();
				results_checked++;
				if (result_value !== head.value)
					note_failure($sformatf("result %0d value: expected %h, got %h",
						results_checked, head.value, result_value));
				if (status !== head.code)
					note_failure($sformatf("result %0d status: expected %0d, got %0d",
						results_checked, head.code, status));
			end
		end
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("watchdog: no transfer for %0d cycles, %0d results pending",
				idle_cycles, pending_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
